FILE: sv/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP response header parser package
// Byte codes, fixed header texts, phase and value kind types shared by the
// parser and its checker.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int TDATA_W = 96;
  localparam int TEXT_W  = 144;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [TEXT_W-1:0] PREFIX_TEXT  = "HTTP/";
  localparam logic [TEXT_W-1:0] CL_TEXT      = "Content-Length:";
  localparam logic [TEXT_W-1:0] TE_TEXT      = "Transfer-Encoding:";
  localparam logic [TEXT_W-1:0] CONN_TEXT    = "Connection:";
  localparam logic [TEXT_W-1:0] CHUNKED_TEXT = "chunked";
  localparam logic [TEXT_W-1:0] CLOSE_TEXT   = "close";

  localparam logic [4:0] LEN_PREFIX  = 5'd5;
  localparam logic [4:0] LEN_CL      = 5'd15;
  localparam logic [4:0] LEN_TE      = 5'd18;
  localparam logic [4:0] LEN_CONN    = 5'd11;
  localparam logic [2:0] LEN_CHUNKED = 3'd7;
  localparam logic [2:0] LEN_CLOSE   = 3'd5;

  // Bit positions of the result fields within m_tdata.
  localparam int OUT_HEADERS_DONE = 8;
  localparam int OUT_BAD_RESPONSE = 9;

  typedef enum logic [3:0] {
    PH_PREFIX,
    PH_SEEK_SPACE,
    PH_STATUS,
    PH_SKIP_LINE,
    PH_LINE_START,
    PH_NAME,
    PH_VALUE,
    PH_BLANK_CR,
    PH_BODY,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LENGTH,
    KIND_TRANSFER,
    KIND_CONN
  } kind_t;

endpackage

FILE: sv/http_response_header_parser.sv
// ----------------------------------------------------------------------------
// HTTP response header parser
// Checks the HTTP/ prefix, takes the status code and the Content-Length,
// Transfer-Encoding and Connection headers, then marks body bytes.
// ----------------------------------------------------------------------------
// The parser takes one response byte per request and returns one result per
// byte, and it can take a new byte in every clock cycle while results are
// taken: each byte is decoded combinationally against the parse state, its
// result is held in an output register, and a new byte is accepted in the
// same cycle as the previous result is taken, so bytes follow with no gap.
// The result of an accepted byte appears in the cycle after it. The header
// matchers, multiply-by-ten accumulators and body counter all sit before the
// output register; the 32-bit length accumulate sets the longest path.
// A byte with tlast set closes the response and the parser starts afresh.
module http_response_header_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] data_byte
  input  logic                        s_tlast,   // last_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] body_byte, [8] headers_done, [9] bad_response, [25:10] status_value,
  // [57:26] length_value, [58] chunked_flag, [59] close_flag,
  // [91:60] body_length, [95:92] zero
  output logic [hrhp_pkg::TDATA_W-1:0] m_tdata,
  output logic                        m_tuser,   // body_valid
  output logic                        m_tlast    // response_end
);

  hrhp_pkg::phase_t phase, phase_next;
  hrhp_pkg::kind_t  value_kind, value_kind_next;
  logic [4:0]  match_position, match_position_next;
  logic [2:0]  name_candidates, name_candidates_next;
  logic [2:0]  chunked_match_position, chunked_match_position_next;
  logic [2:0]  close_match_position, close_match_position_next;
  logic [15:0] status_accumulator, status_accumulator_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [31:0] body_counter, body_counter_next;
  logic        chunked_seen, chunked_seen_next;
  logic        close_seen, close_seen_next;
  logic        pending_carriage_return, pending_carriage_return_next;
  logic        bad_seen, bad_seen_next;

  logic        accept;
  logic [7:0]  b;
  logic        is_digit;
  logic [3:0]  digit;
  logic [2:0]  cand_eff;
  logic [4:0]  pos_eff;
  logic [2:0]  live;
  logic        do_name;
  logic        do_body;
  logic        body_valid;
  logic        headers_done;
  logic        bad_response;
  logic [3:0]  chunked_step;
  logic [3:0]  close_step;

  function automatic logic [7:0] text_char(input logic [hrhp_pkg::TEXT_W-1:0] text,
                                           input logic [4:0] len, input logic [4:0] pos);
    logic [4:0] ci;
    ci = len - pos - 5'd1;
    return text[{ci, 3'b000} +: 8];
  endfunction

  function automatic logic [3:0] seek_step(input logic [2:0] pos, input logic [7:0] ch,
                                           input logic [hrhp_pkg::TEXT_W-1:0] text,
                                           input logic [2:0] len);
    logic [2:0] p;
    logic [2:0] nx;
    logic       hit;
    p = (pos >= len) ? 3'd0 : pos;
    if (ch == text_char(text, {2'b00, len}, {2'b00, p})) begin
      nx = p + 3'd1;
    end else begin
      nx = (ch == text_char(text, {2'b00, len}, 5'd0)) ? 3'd1 : 3'd0;
    end
    hit = 1'b0;
    if (nx >= len) begin
      hit = 1'b1;
      nx  = 3'd0;
    end
    return {hit, nx};
  endfunction

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;
  assign is_digit = (b >= hrhp_pkg::CH_ZERO) && (b <= hrhp_pkg::CH_NINE);
  assign digit    = 4'(b - hrhp_pkg::CH_ZERO);

  // A header line starts its name match afresh with all three names live.
  assign cand_eff = (phase == hrhp_pkg::PH_LINE_START) ? 3'b111 : name_candidates;
  assign pos_eff  = (phase == hrhp_pkg::PH_LINE_START) ? 5'd0 : match_position;

  assign live[0] = cand_eff[0] && (pos_eff < hrhp_pkg::LEN_CL) &&
                   (b == text_char(hrhp_pkg::CL_TEXT, hrhp_pkg::LEN_CL, pos_eff));
  assign live[1] = cand_eff[1] && (pos_eff < hrhp_pkg::LEN_TE) &&
                   (b == text_char(hrhp_pkg::TE_TEXT, hrhp_pkg::LEN_TE, pos_eff));
  assign live[2] = cand_eff[2] && (pos_eff < hrhp_pkg::LEN_CONN) &&
                   (b == text_char(hrhp_pkg::CONN_TEXT, hrhp_pkg::LEN_CONN, pos_eff));

  assign chunked_step = seek_step(chunked_match_position, b, hrhp_pkg::CHUNKED_TEXT,
                                  hrhp_pkg::LEN_CHUNKED);
  assign close_step   = seek_step(close_match_position, b, hrhp_pkg::CLOSE_TEXT,
                                  hrhp_pkg::LEN_CLOSE);

  always_comb begin
    phase_next                   = phase;
    value_kind_next              = value_kind;
    match_position_next          = match_position;
    name_candidates_next         = name_candidates;
    chunked_match_position_next  = chunked_match_position;
    close_match_position_next    = close_match_position;
    status_accumulator_next      = status_accumulator;
    length_accumulator_next      = length_accumulator;
    body_counter_next            = body_counter;
    chunked_seen_next            = chunked_seen;
    close_seen_next              = close_seen;
    pending_carriage_return_next = pending_carriage_return;
    bad_seen_next                = bad_seen;
    do_name                      = 1'b0;
    do_body                      = 1'b0;
    body_valid                   = 1'b0;

    unique case (phase)
      hrhp_pkg::PH_PREFIX: begin
        if (match_position < hrhp_pkg::LEN_PREFIX &&
            b == text_char(hrhp_pkg::PREFIX_TEXT, hrhp_pkg::LEN_PREFIX, match_position)) begin
          if (match_position == hrhp_pkg::LEN_PREFIX - 5'd1) begin
            match_position_next = 5'd0;
            phase_next          = hrhp_pkg::PH_SEEK_SPACE;
          end else begin
            match_position_next = match_position + 5'd1;
          end
        end else begin
          bad_seen_next = 1'b1;
          phase_next    = hrhp_pkg::PH_BAD;
        end
      end
      hrhp_pkg::PH_SEEK_SPACE: begin
        if (b == hrhp_pkg::CH_SPACE) begin
          phase_next = hrhp_pkg::PH_STATUS;
        end
      end
      hrhp_pkg::PH_STATUS: begin
        if (is_digit) begin
          status_accumulator_next = 16'(status_accumulator * 16'd10 + {12'd0, digit});
        end else if (b == hrhp_pkg::CH_CR) begin
          pending_carriage_return_next = 1'b1;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end else if (b == hrhp_pkg::CH_LF) begin
          pending_carriage_return_next = 1'b0;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end else begin
          phase_next = hrhp_pkg::PH_SKIP_LINE;
        end
      end
      hrhp_pkg::PH_SKIP_LINE: begin
        if (b == hrhp_pkg::CH_CR) begin
          pending_carriage_return_next = 1'b1;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end else if (b == hrhp_pkg::CH_LF) begin
          pending_carriage_return_next = 1'b0;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end
      end
      hrhp_pkg::PH_LINE_START: begin
        pending_carriage_return_next = 1'b0;
        if (!(pending_carriage_return && b == hrhp_pkg::CH_LF)) begin
          if (b == hrhp_pkg::CH_CR) begin
            phase_next = hrhp_pkg::PH_BLANK_CR;
          end else if (b == hrhp_pkg::CH_LF) begin
            phase_next = hrhp_pkg::PH_BODY;
          end else begin
            value_kind_next = hrhp_pkg::KIND_NONE;
            do_name         = 1'b1;
          end
        end
      end
      hrhp_pkg::PH_NAME: begin
        do_name = 1'b1;
      end
      hrhp_pkg::PH_VALUE: begin
        if (b == hrhp_pkg::CH_CR) begin
          pending_carriage_return_next = 1'b1;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end else if (b == hrhp_pkg::CH_LF) begin
          pending_carriage_return_next = 1'b0;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end else begin
          unique case (value_kind)
            hrhp_pkg::KIND_LENGTH: begin
              if (is_digit) begin
                length_accumulator_next = 32'(length_accumulator * 32'd10 + {28'd0, digit});
                match_position_next     = 5'd1;
              end else if (!(b == hrhp_pkg::CH_SPACE && match_position == 5'd0)) begin
                phase_next = hrhp_pkg::PH_SKIP_LINE;
              end
            end
            hrhp_pkg::KIND_TRANSFER: begin
              chunked_match_position_next = chunked_step[2:0];
              if (chunked_step[3]) begin
                chunked_seen_next = 1'b1;
              end
            end
            hrhp_pkg::KIND_CONN: begin
              close_match_position_next = close_step[2:0];
              if (close_step[3]) begin
                close_seen_next = 1'b1;
              end
            end
            hrhp_pkg::KIND_NONE: begin
              phase_next = hrhp_pkg::PH_SKIP_LINE;
            end
            default: begin
              phase_next = hrhp_pkg::PH_SKIP_LINE;
            end
          endcase
        end
      end
      hrhp_pkg::PH_BLANK_CR: begin
        phase_next = hrhp_pkg::PH_BODY;
        do_body    = (b != hrhp_pkg::CH_LF);
      end
      hrhp_pkg::PH_BODY: begin
        do_body = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_name) begin
      name_candidates_next = cand_eff;
      match_position_next  = pos_eff;
      if (live == 3'b000) begin
        if (b == hrhp_pkg::CH_CR) begin
          pending_carriage_return_next = 1'b1;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end else if (b == hrhp_pkg::CH_LF) begin
          pending_carriage_return_next = 1'b0;
          phase_next                   = hrhp_pkg::PH_LINE_START;
        end else begin
          phase_next = hrhp_pkg::PH_SKIP_LINE;
        end
      end else if ((live[0] && pos_eff == hrhp_pkg::LEN_CL - 5'd1) ||
                   (live[1] && pos_eff == hrhp_pkg::LEN_TE - 5'd1) ||
                   (live[2] && pos_eff == hrhp_pkg::LEN_CONN - 5'd1)) begin
        phase_next                  = hrhp_pkg::PH_VALUE;
        match_position_next         = 5'd0;
        chunked_match_position_next = 3'd0;
        close_match_position_next   = 3'd0;
        if (live[0] && pos_eff == hrhp_pkg::LEN_CL - 5'd1) begin
          value_kind_next         = hrhp_pkg::KIND_LENGTH;
          length_accumulator_next = 32'd0;
        end else if (live[1] && pos_eff == hrhp_pkg::LEN_TE - 5'd1) begin
          value_kind_next = hrhp_pkg::KIND_TRANSFER;
        end else begin
          value_kind_next = hrhp_pkg::KIND_CONN;
        end
      end else begin
        name_candidates_next = live;
        match_position_next  = pos_eff + 5'd1;
        phase_next           = hrhp_pkg::PH_NAME;
      end
    end

    if (do_body) begin
      if (!(length_accumulator != 32'd0 && body_counter >= length_accumulator)) begin
        body_valid = 1'b1;
        if (body_counter != 32'hffff_ffff) begin
          body_counter_next = body_counter + 32'd1;
        end
      end
    end
  end

  assign headers_done = (phase_next == hrhp_pkg::PH_BODY);
  assign bad_response = bad_seen_next || (s_tlast && phase_next == hrhp_pkg::PH_PREFIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid                <= 1'b0;
      phase                   <= hrhp_pkg::PH_PREFIX;
      value_kind              <= hrhp_pkg::KIND_NONE;
      match_position          <= 5'd0;
      name_candidates         <= 3'b111;
      chunked_match_position  <= 3'd0;
      close_match_position    <= 3'd0;
      status_accumulator      <= 16'd0;
      length_accumulator      <= 32'd0;
      body_counter            <= 32'd0;
      chunked_seen            <= 1'b0;
      close_seen              <= 1'b0;
      pending_carriage_return <= 1'b0;
      bad_seen                <= 1'b0;
    end else begin
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && s_tlast) begin
        phase                   <= hrhp_pkg::PH_PREFIX;
        value_kind              <= hrhp_pkg::KIND_NONE;
        match_position          <= 5'd0;
        name_candidates         <= 3'b111;
        chunked_match_position  <= 3'd0;
        close_match_position    <= 3'd0;
        status_accumulator      <= 16'd0;
        length_accumulator      <= 32'd0;
        body_counter            <= 32'd0;
        chunked_seen            <= 1'b0;
        close_seen              <= 1'b0;
        pending_carriage_return <= 1'b0;
        bad_seen                <= 1'b0;
      end else if (accept) begin
        phase                   <= phase_next;
        value_kind              <= value_kind_next;
        match_position          <= match_position_next;
        name_candidates         <= name_candidates_next;
        chunked_match_position  <= chunked_match_position_next;
        close_match_position    <= close_match_position_next;
        status_accumulator      <= status_accumulator_next;
        length_accumulator      <= length_accumulator_next;
        body_counter            <= body_counter_next;
        chunked_seen            <= chunked_seen_next;
        close_seen              <= close_seen_next;
        pending_carriage_return <= pending_carriage_return_next;
        bad_seen                <= bad_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'd0, body_counter_next, close_seen_next, chunked_seen_next,
                  length_accumulator_next, status_accumulator_next,
                  bad_response, headers_done, b};
      m_tuser <= body_valid;
      m_tlast <= s_tlast;
    end
  end

endmodule

FILE: sv/hrhp_checker.sv
// ----------------------------------------------------------------------------
// HTTP response header parser checker
// Port-level assertions on the parser's requests and results.
// ----------------------------------------------------------------------------
module hrhp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [hrhp_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tuser
);

  // Every accepted request yields a result in the following cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request produced no result");

  // A waiting result keeps its contents.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Body bytes only appear once the headers are complete.
  a_body_after_headers: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[hrhp_pkg::OUT_HEADERS_DONE])
    else $error("body byte before end of headers");

  // A response with a bad prefix never reaches its body.
  a_bad_no_headers: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[hrhp_pkg::OUT_HEADERS_DONE] &&
                   m_tdata[hrhp_pkg::OUT_BAD_RESPONSE]))
    else $error("bad response reported completed headers");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
